>>> hw/rtl/bsfs_pkg.sv
`default_nettype none
package bsfs_pkg;

  localparam int PLAY_WIDTH  = 640;
  localparam int PLAY_HEIGHT = 480;
  localparam int SPRITE_SIZE = 16;
  localparam int BLIP_LENGTH = 15;

  localparam int XPIX_W = 10;
  localparam int YPIX_W = 9;
  localparam int POS_W  = 10;
  localparam int LIM_W  = 11;
  localparam int VEL_W  = 16;
  localparam int FRAC_W = 8;
  localparam int TMR_W  = 4;
  localparam int VOL_W  = 6;
  localparam int CIDX_W = 3;

  localparam logic [XPIX_W-1:0] X_PIX_RST = XPIX_W'(64);
  localparam logic [YPIX_W-1:0] Y_PIX_RST = YPIX_W'(48);
  localparam logic [VEL_W-1:0]  X_VEL_RST = VEL_W'(384);
  localparam logic [VEL_W-1:0]  Y_VEL_RST = VEL_W'(192);

  localparam logic [9:0] BOX_LEFT_RST   = 10'd304;
  localparam logic [8:0] BOX_TOP_RST    = 9'd200;
  localparam logic [9:0] BOX_WIDTH_RST  = 10'd80;
  localparam logic [8:0] BOX_HEIGHT_RST = 9'd80;

  function automatic int wall_limit(int play, int range);
    int lim;
    lim = play - SPRITE_SIZE;
    if (lim > range) lim = range;
    if (lim < 1) lim = 1;
    return lim;
  endfunction

  localparam logic [LIM_W-1:0] X_LIMIT = LIM_W'(wall_limit(PLAY_WIDTH, 1024));
  localparam logic [LIM_W-1:0] Y_LIMIT = LIM_W'(wall_limit(PLAY_HEIGHT, 512));
  localparam logic [TMR_W-1:0] BLIP_START = TMR_W'(BLIP_LENGTH);
  localparam logic [POS_W:0]   SPRITE_EXT = (POS_W+1)'(SPRITE_SIZE);

  typedef enum logic [CIDX_W-1:0] {
    CFG_BOX_LEFT   = 3'd0,
    CFG_BOX_TOP    = 3'd1,
    CFG_BOX_WIDTH  = 3'd2,
    CFG_BOX_HEIGHT = 3'd3,
    CFG_SPEED_X    = 3'd4,
    CFG_SPEED_Y    = 3'd5,
    CFG_NOTE_EN    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0] box_left;
    logic [8:0] box_top;
    logic [9:0] box_width;
    logic [8:0] box_height;
    logic       note_enable;
  } box_cfg_t;

  typedef struct packed {
    logic [XPIX_W-1:0] x_pix;
    logic [YPIX_W-1:0] y_pix;
    logic [FRAC_W-1:0] x_frac;
    logic [FRAC_W-1:0] y_frac;
    logic [VEL_W-1:0]  x_vel;
    logic [VEL_W-1:0]  y_vel;
    logic [TMR_W-1:0]  timer;
    logic              last_hit;
  } sprite_state_t;

  typedef struct packed {
    logic [XPIX_W-1:0] pixel_x;
    logic [YPIX_W-1:0] pixel_y;
    logic              overlap;
    logic              wall_bounce;
    logic [VOL_W-1:0]  blip_volume;
    logic              note_start;
    logic              note_release;
  } frame_res_t;

  typedef struct packed {
    logic [POS_W-1:0]  pix;
    logic [FRAC_W-1:0] frac;
    logic [VEL_W-1:0]  vel;
    logic              bounce;
  } axis_t;

  function automatic axis_t move_axis(logic [POS_W-1:0] pix, logic [FRAC_W-1:0] frac,
                                      logic [VEL_W-1:0] vel, logic [LIM_W-1:0] lim);
    axis_t            r;
    logic [FRAC_W:0]  f;
    logic [POS_W+1:0] p;
    f = {1'b0, frac} + {1'b0, vel[FRAC_W-1:0]};
    p = {2'b00, pix} + {{4{vel[VEL_W-1]}}, vel[VEL_W-1:FRAC_W]}
        + {{(POS_W+1){1'b0}}, f[FRAC_W]};
    r.frac   = f[FRAC_W-1:0];
    r.pix    = p[POS_W-1:0];
    r.vel    = vel;
    r.bounce = 1'b0;
    if (p[POS_W+1]) begin
      r.pix    = '0;
      r.frac   = '0;
      r.bounce = 1'b1;
    end else if ($signed(p) >= $signed({1'b0, lim})) begin
      r.pix    = POS_W'(lim - LIM_W'(1));
      r.frac   = '0;
      r.bounce = 1'b1;
    end
    if (r.bounce) r.vel = VEL_W'(0) - vel;
    return r;
  endfunction

  function automatic logic span_hit(logic [POS_W-1:0] pos, logic [POS_W-1:0] left,
                                    logic [POS_W-1:0] size);
    logic [POS_W:0] far_edge;
    logic [POS_W:0] spr_edge;
    far_edge = {1'b0, left} + {1'b0, size};
    spr_edge = {1'b0, pos} + SPRITE_EXT;
    return ({1'b0, pos} < far_edge) && ({1'b0, left} < spr_edge);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bsfs_step.sv
`default_nettype none
module bsfs_step
  import bsfs_pkg::*;
(
  input  sprite_state_t state_i,
  input  box_cfg_t      cfg_i,
  input  logic          advance_i,
  output sprite_state_t state_o,
  output frame_res_t    res_o
);

  axis_t            ax;
  axis_t            ay;
  logic             bounce;
  logic             hit;
  logic             edge_seen;
  logic [TMR_W-1:0] tmr;

  always_comb begin
    ax = move_axis(state_i.x_pix, state_i.x_frac, state_i.x_vel, X_LIMIT);
    ay = move_axis({1'b0, state_i.y_pix}, state_i.y_frac, state_i.y_vel, Y_LIMIT);

    state_o = state_i;
    bounce  = 1'b0;
    if (advance_i) begin
      state_o.x_pix  = ax.pix;
      state_o.x_frac = ax.frac;
      state_o.x_vel  = ax.vel;
      state_o.y_pix  = ay.pix[YPIX_W-1:0];
      state_o.y_frac = ay.frac;
      state_o.y_vel  = ay.vel;
      bounce         = ax.bounce | ay.bounce;
    end

    hit = span_hit(state_o.x_pix, cfg_i.box_left, cfg_i.box_width) &&
          span_hit({1'b0, state_o.y_pix}, {1'b0, cfg_i.box_top}, {1'b0, cfg_i.box_height});

    edge_seen = advance_i && cfg_i.note_enable && (hit != state_i.last_hit);
    if (edge_seen) state_o.last_hit = hit;

    tmr = bounce ? BLIP_START : state_i.timer;
    if (advance_i && (tmr != '0)) tmr = tmr - TMR_W'(1);
    state_o.timer = tmr;

    res_o.pixel_x      = state_o.x_pix;
    res_o.pixel_y      = state_o.y_pix;
    res_o.overlap      = hit;
    res_o.wall_bounce  = bounce;
    res_o.blip_volume  = {state_o.timer, 2'b00};
    res_o.note_start   = edge_seen & hit;
    res_o.note_release = edge_seen & ~hit;
  end

endmodule
`default_nettype wire

>>> hw/rtl/bouncing_sprite_frame_step_top.sv
// channel  | valid / ready           | payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o | advance_i
// out      | out_valid_o/out_ready_i | pixel_x_o pixel_y_o overlap_o wall_bounce_o
//          |                         | blip_volume_o note_start_o note_release_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// One word per cycle unless out_ready_i stalls: the frame step runs in the
// accept cycle and lands in the result register; it appears in the next cycle.
// in_ready_o is high while the result register is empty or being drained.
// cfg_ready_o is always high. Reset loads the start position and speeds.
`default_nettype none
module bouncing_sprite_frame_step_top
  import bsfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                advance_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [XPIX_W-1:0]   pixel_x_o,
  output logic [YPIX_W-1:0]   pixel_y_o,
  output logic                overlap_o,
  output logic                wall_bounce_o,
  output logic [VOL_W-1:0]    blip_volume_o,
  output logic                note_start_o,
  output logic                note_release_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [VEL_W-1:0]    cfg_data_i
);

  sprite_state_t st_q;
  sprite_state_t st_d;
  box_cfg_t      cfg_q;
  box_cfg_t      cfg_d;
  frame_res_t    res_q;
  frame_res_t    res_d;
  logic          out_valid_q;
  logic          in_fire;
  logic          cfg_fire;

  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  bsfs_step u_step (
    .state_i   (st_q),
    .cfg_i     (cfg_q),
    .advance_i (advance_i),
    .state_o   (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.x_pix         <= X_PIX_RST;
      st_q.y_pix         <= Y_PIX_RST;
      st_q.x_frac        <= '0;
      st_q.y_frac        <= '0;
      st_q.x_vel         <= X_VEL_RST;
      st_q.y_vel         <= Y_VEL_RST;
      st_q.timer         <= '0;
      st_q.last_hit      <= 1'b0;
      cfg_q.box_left     <= BOX_LEFT_RST;
      cfg_q.box_top      <= BOX_TOP_RST;
      cfg_q.box_width    <= BOX_WIDTH_RST;
      cfg_q.box_height   <= BOX_HEIGHT_RST;
      cfg_q.note_enable  <= 1'b1;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (cfg_fire && cfg_idx_e'(cfg_index_i) == CFG_SPEED_X) begin
        st_q.x_vel <= cfg_data_i;
      end else if (cfg_fire && cfg_idx_e'(cfg_index_i) == CFG_SPEED_Y) begin
        st_q.y_vel <= cfg_data_i;
      end else if (in_fire) begin
        st_q <= st_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BOX_LEFT:   cfg_d.box_left    = cfg_data_i[9:0];
        CFG_BOX_TOP:    cfg_d.box_top     = cfg_data_i[8:0];
        CFG_BOX_WIDTH:  cfg_d.box_width   = cfg_data_i[9:0];
        CFG_BOX_HEIGHT: cfg_d.box_height  = cfg_data_i[8:0];
        CFG_NOTE_EN:    cfg_d.note_enable = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // hold the word until taken
  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = res_q.pixel_x;
  assign pixel_y_o      = res_q.pixel_y;
  assign overlap_o      = res_q.overlap;
  assign wall_bounce_o  = res_q.wall_bounce;
  assign blip_volume_o  = res_q.blip_volume;
  assign note_start_o   = res_q.note_start;
  assign note_release_o = res_q.note_release;

endmodule
`default_nettype wire
